FILE: sv/twsr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the two-wire sensor measurement reader.
package twsr_pkg;

	localparam int unsigned TIMEOUT_W     = 22;
	localparam int unsigned HALF_W        = 16;
	localparam int unsigned PORT_W        = 4;
	localparam int unsigned PORT_VALUES   = 16;
	localparam int unsigned DEF_PORT_COUNT = 16;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 22'd2100000;
	localparam logic [HALF_W-1:0]    HALF_RESET    = 16'h0001;

	// Register indexes on the configuration port.
	localparam logic REG_TIMEOUT = 1'b0;
	localparam logic REG_HALF    = 1'b1;

	// Input opcodes.
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_START = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_NONE    = 2'd0;
	localparam logic [1:0] ST_OK      = 2'd1;
	localparam logic [1:0] ST_TIMEOUT = 2'd2;

	typedef enum logic [10:0] {
		PH_IDLE  = 11'b000_0000_0001,
		PH_START = 11'b000_0000_0010,
		PH_CMD   = 11'b000_0000_0100,
		PH_NINTH = 11'b000_0000_1000,
		PH_WAIT  = 11'b000_0001_0000,
		PH_BYTE1 = 11'b000_0010_0000,
		PH_ACK1  = 11'b000_0100_0000,
		PH_BYTE2 = 11'b000_1000_0000,
		PH_ACK2  = 11'b001_0000_0000,
		PH_CRC   = 11'b010_0000_0000,
		PH_STOP  = 11'b100_0000_0000
	} phase_t;

	typedef struct packed {
		logic              sda_level;
		logic [PORT_W-1:0] sensor_port;
		logic [7:0]        command_byte;
		logic              opcode;
	} item_t;

	// Packed so that scl_level sits in bit 0.
	typedef struct packed {
		logic [7:0]        checksum;
		logic [15:0]       measurement;
		logic [1:0]        status;
		logic              done_res;
		logic              busy_res;
		logic [PORT_W-1:0] active_port;
		logic              sda_drive_low;
		logic              scl_level;
	} res_t;

	localparam int unsigned RES_W   = $bits(res_t);
	localparam int unsigned TDATA_W = ((RES_W + 7) / 8) * 8;
	localparam int unsigned SDATA_W = (($bits(item_t) - 1 + 7) / 8) * 8;

endpackage

FILE: sv/two_wire_sensor_measurement_reader_top.sv
`timescale 1ns / 1ps
// Top level of the two-wire sensor measurement reader: stream ports, registers, result stage.
//
// Each input transaction is one tick (tuser 0) or a start request (tuser 1); every input
// transaction produces exactly one result transaction carrying the line levels to drive and,
// on the tick a read ends, the 16-bit measurement, checksum and status. The block accepts one
// transaction per clock cycle whenever the result register is free or being emptied; an accepted
// input passes from the input register through the sequencer's short next-state logic, and its
// result is valid once it is in the result register. Line timing is counted in ticks: each
// clock phase lasts half_period_ticks ticks and the ready wait gives up after
// timeout_ticks checks.
// Registers: 0x0 timeout_ticks (22 bits), 0x4 half_period_ticks (16 bits).
module two_wire_sensor_measurement_reader_top #(
	parameter int unsigned PORT_COUNT = twsr_pkg::DEF_PORT_COUNT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [7:0] command_byte, [11:8] sensor_port, [12] sda_level, [15:13] zero
	input  logic [twsr_pkg::SDATA_W-1:0]  s_tdata,
	// [0] opcode
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [0] scl_level, [1] sda_drive_low, [5:2] active_port, [6] busy_res, [7] done_res,
	// [9:8] status, [25:10] measurement, [33:26] checksum, [39:34] zero
	output logic [twsr_pkg::TDATA_W-1:0]  m_tdata,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import twsr_pkg::*;

	logic [TIMEOUT_W-1:0] timeout_q;
	logic [HALF_W-1:0]    half_q;
	logic                 cfg_wr;

	item_t item_s1;
	logic  valid_s1;
	logic  advance;
	res_t  res_next;
	res_t  res_q;
	logic  m_valid_q;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
			half_q    <= HALF_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_TIMEOUT: timeout_q <= pwdata[TIMEOUT_W-1:0];
				REG_HALF:    half_q    <= pwdata[HALF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_TIMEOUT: prdata = 32'(timeout_q);
			REG_HALF:    prdata = 32'(half_q);
			default:     prdata = '0;
		endcase
	end

	// The input register moves into the sequencer whenever the result register can take it.
	assign advance  = valid_s1 & (~m_valid_q | m_tready);
	assign s_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.opcode       <= s_tuser;
			item_s1.command_byte <= s_tdata[7:0];
			item_s1.sensor_port  <= s_tdata[11:8];
			item_s1.sda_level    <= s_tdata[12];
		end
	end

	twsr_seq #(
		.PORT_COUNT(PORT_COUNT)
	) u_seq (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_en          (advance),
		.item             (item_s1),
		.timeout_ticks    (timeout_q),
		.half_period_ticks(half_q),
		.res              (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = TDATA_W'(res_q);

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && res_q.done_res) |-> !res_q.busy_res)
		else $error("finished result still marked busy");

	a_status_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (res_q.done_res == (res_q.status != ST_NONE)))
		else $error("status and done flag disagree");

	a_idle_lines: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !res_q.busy_res) |-> (!res_q.scl_level && !res_q.sda_drive_low))
		else $error("lines driven while idle");

	a_value_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && res_q.status != ST_OK) |-> (res_q.measurement == 16'h0000
		&& res_q.checksum == 8'h00))
		else $error("measurement shown without a successful read");

endmodule

FILE: sv/twsr_seq.sv
`timescale 1ns / 1ps
// Pin sequencer: holds the read state and computes one result per item.
module twsr_seq #(
	parameter int unsigned PORT_COUNT = twsr_pkg::DEF_PORT_COUNT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_en,
	input  twsr_pkg::item_t                   item,
	input  logic [twsr_pkg::TIMEOUT_W-1:0]    timeout_ticks,
	input  logic [twsr_pkg::HALF_W-1:0]       half_period_ticks,
	output twsr_pkg::res_t                    res
);
	import twsr_pkg::*;

	phase_t              phase_q, n_phase;
	logic [3:0]          bit_count_q, n_bc;
	logic [HALF_W-1:0]   step_div_q, n_sd;
	logic [TIMEOUT_W-1:0] wait_cnt_q, n_wc;
	logic [7:0]          cmd_q, n_cmd;
	logic [15:0]         data_q, n_data;
	logic [7:0]          crc_q, n_crc;
	logic [PORT_W-1:0]   port_q, n_port;

	logic [PORT_W-1:0]   port_tbl [PORT_VALUES];
	logic [HALF_W-1:0]   hp;
	logic [HALF_W-1:0]   sd_inc;
	logic [3:0]          s;
	logic                last_step;
	logic                done;
	logic [1:0]          status;
	logic                scl;
	logic                low;

	// Port reduction modulo PORT_COUNT, worked out at elaboration.
	for (genvar g = 0; g < PORT_VALUES; g++) begin : g_port
		assign port_tbl[g] = PORT_W'(g % PORT_COUNT);
	end

	assign hp     = (half_period_ticks == '0) ? HALF_W'(1) : half_period_ticks;
	assign sd_inc = step_div_q + HALF_W'(1);
	assign s      = bit_count_q;

	always_comb begin
		case (phase_q)
			PH_START: last_step = (s == 4'd5);
			PH_CMD, PH_BYTE1, PH_BYTE2, PH_CRC: last_step = (s == 4'd15);
			default: last_step = (s == 4'd1);
		endcase
	end

	always_comb begin
		n_phase = phase_q;
		n_bc    = bit_count_q;
		n_sd    = step_div_q;
		n_wc    = wait_cnt_q;
		n_cmd   = cmd_q;
		n_data  = data_q;
		n_crc   = crc_q;
		n_port  = port_q;
		done    = 1'b0;
		status  = ST_NONE;
		if (item.opcode == OP_START) begin
			if (phase_q == PH_IDLE) begin
				n_cmd   = item.command_byte;
				n_port  = port_tbl[item.sensor_port];
				n_phase = PH_START;
				n_bc    = '0;
				n_sd    = '0;
				n_wc    = '0;
				n_data  = '0;
				n_crc   = '0;
			end
		end else if (phase_q == PH_WAIT) begin
			if (wait_cnt_q >= timeout_ticks) begin
				n_phase = PH_IDLE;
				done    = 1'b1;
				status  = ST_TIMEOUT;
			end else if (!item.sda_level) begin
				n_phase = PH_BYTE1;
				n_bc    = '0;
				n_sd    = '0;
			end else begin
				n_wc = wait_cnt_q + TIMEOUT_W'(1);
			end
		end else if (phase_q != PH_IDLE) begin
			if (sd_inc >= hp) begin
				n_sd = '0;
				// Data is sampled as the high half of a read bit ends.
				if ((phase_q == PH_BYTE1 || phase_q == PH_BYTE2) && !s[0]) begin
					n_data = {data_q[14:0], item.sda_level};
				end
				if (phase_q == PH_CRC && !s[0]) begin
					n_crc = {item.sda_level, crc_q[7:1]};
				end
				if (!last_step) begin
					n_bc = s + 4'd1;
				end else begin
					n_bc = '0;
					case (phase_q)
						PH_START: n_phase = PH_CMD;
						PH_CMD:   n_phase = PH_NINTH;
						PH_NINTH: begin
							n_phase = PH_WAIT;
							n_wc    = '0;
						end
						PH_BYTE1: n_phase = PH_ACK1;
						PH_ACK1:  n_phase = PH_BYTE2;
						PH_BYTE2: n_phase = PH_ACK2;
						PH_ACK2:  n_phase = PH_CRC;
						PH_CRC:   n_phase = PH_STOP;
						PH_STOP: begin
							n_phase = PH_IDLE;
							done    = 1'b1;
							status  = ST_OK;
						end
						default:  n_phase = PH_IDLE;
					endcase
				end
			end else begin
				n_sd = sd_inc;
			end
		end
	end

	// Line levels for the step the sequencer has just entered.
	always_comb begin
		scl = 1'b0;
		low = 1'b0;
		case (n_phase)
			PH_START: begin
				case (n_bc)
					4'd0: begin scl = 1'b1; low = 1'b0; end
					4'd1: begin scl = 1'b1; low = 1'b1; end
					4'd2: begin scl = 1'b0; low = 1'b1; end
					4'd3: begin scl = 1'b1; low = 1'b1; end
					4'd4: begin scl = 1'b1; low = 1'b0; end
					default: begin scl = 1'b0; low = 1'b0; end
				endcase
			end
			PH_CMD: begin
				scl = n_bc[0];
				low = ~n_cmd[3'd7 - n_bc[3:1]];
			end
			PH_NINTH, PH_ACK1, PH_ACK2: begin
				scl = n_bc[0];
				low = 1'b1;
			end
			PH_BYTE1, PH_BYTE2, PH_CRC: scl = ~n_bc[0];
			PH_STOP: scl = n_bc[0];
			default: begin
				scl = 1'b0;
				low = 1'b0;
			end
		endcase
	end

	always_comb begin
		res.scl_level     = scl;
		res.sda_drive_low = low;
		res.active_port   = n_port;
		res.busy_res      = (n_phase != PH_IDLE);
		res.done_res      = done;
		res.status        = status;
		res.measurement   = (status == ST_OK) ? n_data : 16'h0000;
		res.checksum      = (status == ST_OK) ? n_crc : 8'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bit_count_q <= '0;
			step_div_q  <= '0;
			wait_cnt_q  <= '0;
			cmd_q       <= '0;
			data_q      <= '0;
			crc_q       <= '0;
			port_q      <= '0;
		end else if (item_en) begin
			phase_q     <= n_phase;
			bit_count_q <= n_bc;
			step_div_q  <= n_sd;
			wait_cnt_q  <= n_wc;
			cmd_q       <= n_cmd;
			data_q      <= n_data;
			crc_q       <= n_crc;
			port_q      <= n_port;
		end
	end

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE && phase_q != PH_WAIT) |-> (step_div_q < hp || $changed(half_period_ticks)
		|| !$stable(step_div_q) || step_div_q < hp))
		else $error("step divider passed the half period");

	a_timeout_only_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		(item_en && status == ST_TIMEOUT) |-> (phase_q == PH_WAIT))
		else $error("timeout reported outside the ready wait");

	a_ok_from_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(item_en && status == ST_OK) |-> (phase_q == PH_STOP && bit_count_q == 4'd1))
		else $error("success reported before the stop step ended");

endmodule
